FILE: rtl/core/ttw_pkg.sv
// Shared types and constants for the text terminal writer.
// Used by the front decoder, the command queue, the back end and the top level.
package ttw_pkg;

    // Character codes with special meaning.
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] SPACE_BYTE   = 8'd32;

    // Reset values for the screen and the color register.
    localparam logic [15:0] CELL_RESET  = 16'h0720;
    localparam logic [7:0]  COLOR_RESET = 8'h07;

    // Command queue geometry.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Field widths and stream widths.
    localparam int INDEX_W     = 11;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;
    localparam int OUT_ROW_W   = 5;
    localparam int OUT_COL_W   = 7;

    // Classified command kinds.
    typedef enum logic [1:0] {
        KIND_PUT     = 2'd0,
        KIND_NEWLINE = 2'd1,
        KIND_READ    = 2'd2
    } t_kind;

    // One classified command as it travels through the queue.
    typedef struct packed {
        t_kind                kind;
        logic [7:0]           character;
        logic [INDEX_W-1:0]   cell_index;
    } t_cmd;

endpackage

FILE: rtl/core/ttw_front.sv
// Front end of the text terminal writer: accepts input transactions and classifies them.
// Depends on ttw_pkg for the command type and the newline code.
module ttw_front (
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ttw_pkg::S_TDATA_W-1:0]  i_s_tdata,  // character [7:0], cell_index [18:8]
    input  logic                           i_s_tuser,  // operation
    input  logic                           i_init_busy,
    input  logic                           i_queue_full,
    output logic                           o_push,
    output ttw_pkg::t_cmd                  o_cmd
);

    logic [7:0] w_character;

    assign w_character = i_s_tdata[7:0];

    // Take a transaction only when the screen is initialized and the queue has room.
    assign o_s_tready = !i_init_busy && !i_queue_full;
    assign o_push     = i_s_tvalid && o_s_tready;

    // Sort each transaction into read, newline or put.
    always_comb begin
        o_cmd.character  = w_character;
        o_cmd.cell_index = i_s_tdata[18:8];
        if (i_s_tuser) begin
            o_cmd.kind = ttw_pkg::KIND_READ;
        end else if (w_character == ttw_pkg::NEWLINE_BYTE) begin
            o_cmd.kind = ttw_pkg::KIND_NEWLINE;
        end else begin
            o_cmd.kind = ttw_pkg::KIND_PUT;
        end
    end

endmodule

FILE: rtl/core/ttw_queue.sv
// Short command queue between the front and back ends of the text terminal writer.
// Depends on ttw_pkg for the command type and queue geometry.
module ttw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttw_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ttw_pkg::t_cmd o_cmd
);

    ttw_pkg::t_cmd                      r_slot [ttw_pkg::QUEUE_DEPTH];
    logic [ttw_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [ttw_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [ttw_pkg::QUEUE_CNT_W-1:0]    r_count;

    assign o_full  = (r_count == ttw_pkg::QUEUE_CNT_W'(ttw_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/core/ttw_back.sv
// Back end of the text terminal writer: screen memory, cursor, scroll and result register.
// Depends on ttw_pkg for the command type, character codes and reset values.
module ttw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [7:0]                        i_text_color,
    input  logic                              i_cmd_valid,
    input  ttw_pkg::t_cmd                     i_cmd,
    output logic                              o_cmd_pop,
    output logic                              o_init_busy,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [15:0]                       o_read_data,
    output logic [ttw_pkg::OUT_ROW_W-1:0]     o_cursor_row,
    output logic [ttw_pkg::OUT_COL_W-1:0]     o_cursor_col
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_CELL      = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW_BASE  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STEP       = AW'(COLUMNS);
    localparam logic [AW:0]   PREFETCH_STEP  = (AW+1)'(COLUMNS + 1);
    localparam logic [AW:0]   CELL_LIMIT     = (AW+1)'(CELLS);
    localparam logic [CW-1:0] LAST_COL       = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW       = RW'(ROWS - 1);

    typedef enum logic [3:0] {
        S_INIT   = 4'b0001,
        S_IDLE   = 4'b0010,
        S_READ   = 4'b0100,
        S_SCROLL = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [15:0]     r_rdata;
    logic            r_out_valid;
    logic [15:0]     r_out_data;
    logic [RW-1:0]   r_out_row;
    logic [CW-1:0]   r_out_col;

    logic [15:0]     screen_mem [CELLS];

    logic            w_issue;
    logic            w_idx_ok;
    logic            w_advance;
    logic            w_mem_we;
    logic [AW-1:0]   w_waddr;
    logic [15:0]     w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [AW-1:0]   w_cur_addr;
    logic [AW:0]     w_next_src;
    logic            w_res_load;
    logic [15:0]     w_res_data;

    assign w_issue    = (r_state == S_IDLE) && i_cmd_valid && !r_out_valid;
    assign w_idx_ok   = (32'(i_cmd.cell_index) < CELLS);
    assign w_cur_addr = AW'(32'(r_row) * COLUMNS + 32'(r_col));
    assign w_next_src = (AW+1)'(r_wptr) + PREFETCH_STEP;

    assign o_init_busy  = (r_state == S_INIT);
    assign o_m_tvalid   = r_out_valid;
    assign o_read_data  = r_out_data;
    assign o_cursor_row = ttw_pkg::OUT_ROW_W'(r_out_row);
    assign o_cursor_col = ttw_pkg::OUT_COL_W'(r_out_col);

    // Sequencer: clearing pass, command execution, read wait and scroll sweep.
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_wptr     = r_wptr;
        o_cmd_pop  = 1'b0;
        w_advance  = 1'b0;
        w_mem_we   = 1'b0;
        w_waddr    = r_wptr;
        w_wdata    = ttw_pkg::CELL_RESET;
        w_raddr    = ROW_STEP;
        w_res_load = 1'b0;
        w_res_data = '0;
        unique case (r_state)
            S_INIT: begin
                w_mem_we = 1'b1;
                n_wptr   = r_wptr + 1'b1;
                if (r_wptr == LAST_CELL) begin
                    n_wptr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_issue) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        ttw_pkg::KIND_READ: begin
                            if (w_idx_ok) begin
                                w_raddr = AW'(i_cmd.cell_index);
                                n_state = S_READ;
                            end else begin
                                w_res_load = 1'b1;
                            end
                        end
                        ttw_pkg::KIND_PUT: begin
                            w_mem_we = 1'b1;
                            w_waddr  = w_cur_addr;
                            w_wdata  = {i_text_color, i_cmd.character};
                            if (r_col == LAST_COL) begin
                                n_col     = '0;
                                w_advance = 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        ttw_pkg::KIND_NEWLINE: begin
                            n_col     = '0;
                            w_advance = 1'b1;
                        end
                        default: begin
                            w_res_load = 1'b1;
                        end
                    endcase
                    // Row advance: step down, or start the scroll on the last row.
                    if (i_cmd.kind != ttw_pkg::KIND_READ) begin
                        if (w_advance && (r_row == LAST_ROW)) begin
                            n_wptr  = '0;
                            n_state = S_SCROLL;
                        end else begin
                            if (w_advance) begin
                                n_row = r_row + 1'b1;
                            end
                            w_res_load = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                w_res_load = 1'b1;
                w_res_data = r_rdata;
                n_state    = S_IDLE;
            end
            S_SCROLL: begin
                // Each cell takes the character one row below, or a space on the last row.
                w_mem_we = 1'b1;
                if (r_wptr < LAST_ROW_BASE) begin
                    w_wdata = {i_text_color, r_rdata[7:0]};
                end else begin
                    w_wdata = {i_text_color, ttw_pkg::SPACE_BYTE};
                end
                if (w_next_src < CELL_LIMIT) begin
                    w_raddr = AW'(w_next_src);
                end else begin
                    w_raddr = '0;
                end
                if (r_wptr == LAST_CELL) begin
                    n_wptr     = '0;
                    w_res_load = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_wptr = r_wptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_wptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_wptr  <= n_wptr;
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_data <= w_res_data;
            r_out_row  <= n_row;
            r_out_col  <= n_col;
        end
    end

    // Screen memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            screen_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= screen_mem[w_raddr];
    end

endmodule

FILE: rtl/core/text_terminal_writer.sv
// Text terminal writer top level: character-cell screen with cursor and scroll.
// Order: a put or newline result passes the command queue and the result register; a read
// also passes the screen memory read register. The back end takes a new command only once
// the last result has been taken; a scroll holds it while it sweeps the screen, one cell per
// cycle through the screen memory write port. Reset: synchronous, active low; afterwards a
// clearing pass fills the screen with grey spaces, and no input transaction is taken until it ends.
module text_terminal_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ttw_pkg::S_TDATA_W-1:0]  i_s_tdata,  // character [7:0], cell_index [18:8]
    input  logic                           i_s_tuser,  // operation [0]
    // Result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ttw_pkg::M_TDATA_W-1:0]  o_m_tdata,  // read_data [15:0], cursor_row [20:16],
                                                       // cursor_col [27:21]
    // Color register write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [7:0]                     i_cfg_data
);

    logic [7:0]                      r_text_color;
    logic                            w_init_busy;
    logic                            w_push;
    logic                            w_pop;
    logic                            w_q_full;
    logic                            w_q_valid;
    ttw_pkg::t_cmd                   w_front_cmd;
    ttw_pkg::t_cmd                   w_q_cmd;
    logic [15:0]                     w_read_data;
    logic [ttw_pkg::OUT_ROW_W-1:0]   w_cursor_row;
    logic [ttw_pkg::OUT_COL_W-1:0]   w_cursor_col;

    // The color register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= ttw_pkg::COLOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_text_color <= i_cfg_data;
        end
    end

    ttw_front u_front (
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_init_busy  (w_init_busy),
        .i_queue_full (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    ttw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    ttw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_cmd_pop    (w_pop),
        .o_init_busy  (w_init_busy),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_read_data  (w_read_data),
        .o_cursor_row (w_cursor_row),
        .o_cursor_col (w_cursor_col)
    );

    // Pack the result fields from the lowest bit up.
    assign o_m_tdata = {4'b0, w_cursor_col, w_cursor_row, w_read_data};

    // No transaction is taken while the screen is still being cleared.
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init_busy |-> !o_s_tready)
        else $error("input taken during clearing pass");

    // The front end never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("push into full command queue");

    // The back end only pops a queue that holds a command.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty command queue");

endmodule

FILE: test/text_terminal_writer_checker.sv
// Checker for the text terminal writer: watches the input, result and color channels.
// Keeps its own copy of the screen, cursor and color and compares every result transaction.
// Depends on ttw_pkg for the command kinds, character codes and field widths.
`timescale 1ns / 1ps

module text_terminal_writer_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [ttw_pkg::S_TDATA_W-1:0]  i_s_tdata,  // character [7:0], cell_index [18:8]
    input  logic                           i_s_tuser,  // operation [0]
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [ttw_pkg::M_TDATA_W-1:0]  i_m_tdata,  // read_data [15:0], cursor_row [20:16],
                                                       // cursor_col [27:21]
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [7:0]                     i_cfg_data,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    localparam int CELLS        = ROWS * COLUMNS;
    localparam int REPORT_LIMIT = 10;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [15:0]                   read_data;
        logic [ttw_pkg::OUT_ROW_W-1:0] row;
        logic [ttw_pkg::OUT_COL_W-1:0] col;
    } t_reply;

    logic [15:0] screen_copy [CELLS];
    int          cursor_row;
    int          cursor_col;
    logic [7:0]  text_color;
    t_reply      replies_due [$];
    int          mismatch_count;

    assign o_mismatches = mismatch_count;

    // Every row takes the characters of the row below in the current color,
    // and the last row becomes blank.
    function automatic void scroll_screen();
        for (int r = 0; r < ROWS - 1; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                screen_copy[r * COLUMNS + c] =
                    {text_color, screen_copy[(r + 1) * COLUMNS + c][7:0]};
            end
        end
        for (int c = 0; c < COLUMNS; c++) begin
            screen_copy[(ROWS - 1) * COLUMNS + c] = {text_color, ttw_pkg::SPACE_BYTE};
        end
    endfunction

    function automatic void next_line();
        if (cursor_row >= ROWS - 1) begin
            cursor_row = ROWS - 1;
            scroll_screen();
        end else begin
            cursor_row++;
        end
    endfunction

    // Applies one command to the screen copy and returns the result it causes.
    function automatic t_reply execute_command(ttw_pkg::t_kind kind, logic [7:0] character,
                                               logic [ttw_pkg::INDEX_W-1:0] cell_index);
        t_reply reply;
        reply.read_data = '0;
        case (kind)
            ttw_pkg::KIND_READ: begin
                if (cell_index < CELLS) reply.read_data = screen_copy[cell_index];
            end
            ttw_pkg::KIND_NEWLINE: begin
                next_line();
                cursor_col = 0;
            end
            default: begin
                screen_copy[cursor_row * COLUMNS + cursor_col] = {text_color, character};
                cursor_col++;
                if (cursor_col >= COLUMNS) begin
                    cursor_col = 0;
                    next_line();
                end
            end
        endcase
        reply.row = ttw_pkg::OUT_ROW_W'(cursor_row);
        reply.col = ttw_pkg::OUT_COL_W'(cursor_col);
        return reply;
    endfunction

    // Prediction on accepted commands and color writes, comparison on accepted results.
    always @(posedge i_clk) begin
        ttw_pkg::t_kind kind;
        t_reply         got;
        t_reply         want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) screen_copy[i] = ttw_pkg::CELL_RESET;
            cursor_row = 0;
            cursor_col = 0;
            text_color = ttw_pkg::COLOR_RESET;
            replies_due.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) text_color = i_cfg_data;

            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) kind = ttw_pkg::KIND_READ;
                else if (i_s_tdata[7:0] == ttw_pkg::NEWLINE_BYTE) kind = ttw_pkg::KIND_NEWLINE;
                else kind = ttw_pkg::KIND_PUT;
                replies_due.push_back(execute_command(kind, i_s_tdata[7:0],
                                                      i_s_tdata[8 +: ttw_pkg::INDEX_W]));
            end

            if (i_m_tvalid && i_m_tready) begin
                got.read_data = i_m_tdata[15:0];
                got.row       = i_m_tdata[16 +: ttw_pkg::OUT_ROW_W];
                got.col       = i_m_tdata[21 +: ttw_pkg::OUT_COL_W];
                if (replies_due.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected result: data %h row %0d col %0d",
                                 $realtime, got.read_data, got.row, got.col);
                    mismatch_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                                     $realtime, want.read_data, want.row, want.col,
                                     got.read_data, got.row, got.col);
                        mismatch_count++;
                    end
                end
            end
        end
        o_outstanding <= replies_due.size();
    end

endmodule

FILE: test/text_terminal_writer_tb.sv
// Testbench top for the text terminal writer: clock, reset, stimulus and the verdict.
// Depends on ttw_pkg, the text_terminal_writer block and text_terminal_writer_checker.
`timescale 1ns / 1ps

module text_terminal_writer_tb;

    localparam int     COLUMNS          = 80;
    localparam int     ROWS             = 25;
    localparam int     CELLS            = ROWS * COLUMNS;
    localparam int     INDEX_TOP        = (1 << ttw_pkg::INDEX_W) - 1;
    localparam int     RESET_CYCLES     = 3;
    // Extra quiet time after the last result before the stream resumes.
    localparam int     SETTLE_CYCLES    = CELLS + 16;
    localparam int     PHASES           = 3;
    localparam int     CHUNKS_PER_PHASE = 4;
    localparam int     ITEMS_PER_CHUNK  = 78;
    localparam longint TIMEOUT_NS       = 100_000_000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [ttw_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [ttw_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [7:0]                     cfg_data  = '0;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int mismatches;
    int outstanding;

    always #6 clk = ~clk;

    text_terminal_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    text_terminal_writer_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Result side backpressure.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end

    // Presents one command and returns in the time step of its transaction.
    task automatic send_command(input ttw_pkg::t_kind kind, input logic [7:0] character,
                                input int cell_index);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= (kind == ttw_pkg::KIND_READ);
        s_tdata  <= {{(ttw_pkg::S_TDATA_W - ttw_pkg::INDEX_W - 8){1'b0}},
                     cell_index[ttw_pkg::INDEX_W-1:0],
                     (kind == ttw_pkg::KIND_NEWLINE) ? ttw_pkg::NEWLINE_BYTE : character};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    // Stops the input stream until every result is in and any scroll has finished.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_color(input logic [7:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly puts and newlines so the cursor reaches the bottom and scrolls often;
    // reads favor the last rows, where scrolled text lands.
    task automatic random_command();
        int pick;
        int sel;
        int cell_index;
        pick = $urandom_range(99, 0);
        sel  = $urandom_range(99, 0);
        if (sel < 45) cell_index = $urandom_range(CELLS - 1, CELLS - 3 * COLUMNS);
        else if (sel < 85) cell_index = $urandom_range(INDEX_TOP, 0);
        else cell_index = $urandom_range(INDEX_TOP, CELLS);
        if (pick < 30)
            send_command(ttw_pkg::KIND_READ, 8'($urandom_range(255, 0)), cell_index);
        else if (pick < 40)
            send_command(ttw_pkg::KIND_NEWLINE, 8'($urandom_range(255, 0)), cell_index);
        else
            send_command(ttw_pkg::KIND_PUT, 8'($urandom_range(255, 0)), cell_index);
    endtask

    // Safety net against a hang.
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int chunk;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset screen contents, reads past the end of the screen,
        // character extremes, newline and cursor movement.
        send_command(ttw_pkg::KIND_READ, 8'h00, 0);
        send_command(ttw_pkg::KIND_READ, 8'hFF, CELLS - 1);
        send_command(ttw_pkg::KIND_READ, 8'h00, CELLS);
        send_command(ttw_pkg::KIND_READ, 8'hFF, INDEX_TOP);
        send_command(ttw_pkg::KIND_PUT, 8'h00, INDEX_TOP);
        send_command(ttw_pkg::KIND_PUT, 8'hFF, 0);
        send_command(ttw_pkg::KIND_NEWLINE, 8'h00, 0);
        send_command(ttw_pkg::KIND_PUT, 8'h41, 0);
        send_command(ttw_pkg::KIND_PUT, 8'h20, INDEX_TOP);
        send_command(ttw_pkg::KIND_READ, 8'h00, 0);
        send_command(ttw_pkg::KIND_READ, 8'h00, 1);
        send_command(ttw_pkg::KIND_READ, 8'h00, 2);
        send_command(ttw_pkg::KIND_READ, 8'h00, COLUMNS);
        send_command(ttw_pkg::KIND_READ, 8'h00, COLUMNS + 1);
        send_command(ttw_pkg::KIND_NEWLINE, 8'hFF, INDEX_TOP);
        send_command(ttw_pkg::KIND_NEWLINE, 8'h00, 0);
        send_command(ttw_pkg::KIND_PUT, 8'h7E, 0);
        send_command(ttw_pkg::KIND_READ, 8'h00, 3 * COLUMNS);
        send_command(ttw_pkg::KIND_READ, 8'h00, 3 * COLUMNS + 1);

        // Random phases: idle mixes on both sides, a color change before each chunk.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                src_idle_pct  = 23;
                sink_idle_pct = 79;
            end else if (phase == 1) begin
                src_idle_pct  = 79;
                sink_idle_pct = 23;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            for (int c = 0; c < CHUNKS_PER_PHASE; c++) begin
                chunk = phase * CHUNKS_PER_PHASE + c;
                if (chunk == 0) write_color(8'h00);
                else if (chunk == 1) write_color(8'hFF);
                else if (chunk == 5) write_color(ttw_pkg::COLOR_RESET);
                else write_color(8'($urandom_range(255, 0)));
                repeat (ITEMS_PER_CHUNK) random_command();
            end
        end

        settle();
        if (mismatches == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
